### hdl/environment_sensor_compensation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the environment sensor compensation block
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ENVIRONMENT_SENSOR_COMPENSATION_ASSERT_SVH
`define ENVIRONMENT_SENSOR_COMPENSATION_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ESC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ESC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// Environment sensor compensation package
// Beat types, codes, micro-operation format and the compensation program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PC_W       = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_CALA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_CALB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_CALC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_CALA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_CALB  = 3'd5;

    localparam logic [23:0] RAW24_DISABLED = 24'h800000;
    localparam logic [15:0] RAW16_DISABLED = 16'h8000;

    // Pressure status codes.
    localparam logic [1:0] PST_OK       = 2'd0;
    localparam logic [1:0] PST_DISABLED = 2'd1;
    localparam logic [1:0] PST_ZERO_DIV = 2'd2;

    // Working register indexes with a fixed meaning.
    localparam logic [3:0] REG_V1   = 4'd11;
    localparam logic [3:0] REG_HUM  = 4'd12;
    localparam logic [3:0] REG_TEMP = 4'd13;
    localparam logic [3:0] REG_PRES = 4'd14;
    localparam logic [3:0] REG_FINE = 4'd15;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
        logic [15:0] raw_humidity;
    } raw_beat_t;

    typedef struct packed {
        logic signed [26:0] temperature_centi;
        logic               temperature_valid;
        logic signed [31:0] pressure_q24_8;
        logic [1:0]         pressure_status;
        logic [16:0]        humidity_q22_10;
        logic               humidity_valid;
    } comp_beat_t;

    typedef enum logic [3:0] {
        OP_END,
        OP_FLD,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ASR,
        OP_MIN,
        OP_MAX
    } alu_op_t;

    typedef enum logic [4:0] {
        F_ADC_T, F_ADC_P, F_RH,
        F_T1, F_T2, F_T3,
        F_P1, F_P2, F_P3, F_P4, F_P5, F_P6, F_P7, F_P8, F_P9,
        F_H1, F_H2, F_H3, F_H4, F_H5, F_H6
    } fld_t;

    typedef struct packed {
        alu_op_t            op;
        logic [3:0]         dst;
        logic [3:0]         src_a;
        logic [3:0]         src_b;
        logic               use_imm;
        logic               wrap;
        logic signed [63:0] imm;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic            start;
        logic            read;
        logic            exec;
        logic            finish;
        logic [PC_W-1:0] pc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic out_free;
    } dp_status_t;

    function automatic uop_t rr(alu_op_t op, logic [3:0] d, logic [3:0] a,
                                logic [3:0] b, logic w);
        uop_t u;
        u.op      = op;
        u.dst     = d;
        u.src_a   = a;
        u.src_b   = b;
        u.use_imm = 1'b0;
        u.wrap    = w;
        u.imm     = '0;
        return u;
    endfunction

    function automatic uop_t ri(alu_op_t op, logic [3:0] d, logic [3:0] a,
                                logic signed [63:0] imm, logic w);
        uop_t u;
        u.op      = op;
        u.dst     = d;
        u.src_a   = a;
        u.src_b   = '0;
        u.use_imm = 1'b1;
        u.wrap    = w;
        u.imm     = imm;
        return u;
    endfunction

    function automatic uop_t fl(logic [3:0] d, fld_t f);
        uop_t u;
        u.op      = OP_FLD;
        u.dst     = d;
        u.src_a   = '0;
        u.src_b   = '0;
        u.use_imm = 1'b1;
        u.wrap    = 1'b0;
        u.imm     = 64'(f);
        return u;
    endfunction

    // Compensation program. Ops flagged with wrap keep 32-bit two's complement
    // semantics; the pressure section runs on the full 64 bits.
    function automatic uop_t prog(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // Temperature
            7'd0:   u = fl(4'd0, F_ADC_T);
            7'd1:   u = fl(4'd1, F_T1);
            7'd2:   u = ri(OP_ASR, 4'd2, 4'd0, 64'sd3, 1'b0);
            7'd3:   u = rr(OP_ADD, 4'd3, 4'd1, 4'd1, 1'b0);
            7'd4:   u = rr(OP_SUB, 4'd2, 4'd2, 4'd3, 1'b0);
            7'd5:   u = ri(OP_ASR, 4'd3, 4'd0, 64'sd4, 1'b0);
            7'd6:   u = rr(OP_SUB, 4'd3, 4'd3, 4'd1, 1'b0);
            7'd7:   u = fl(4'd4, F_T2);
            7'd8:   u = rr(OP_MUL, 4'd2, 4'd2, 4'd4, 1'b1);
            7'd9:   u = ri(OP_ASR, 4'd2, 4'd2, 64'sd11, 1'b0);
            7'd10:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd3, 1'b1);
            7'd11:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd12, 1'b0);
            7'd12:  u = fl(4'd4, F_T3);
            7'd13:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd4, 1'b1);
            7'd14:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd14, 1'b0);
            7'd15:  u = rr(OP_ADD, 4'd2, 4'd2, 4'd3, 1'b1);
            7'd16:  u = ri(OP_ADD, REG_FINE, 4'd2, 64'sd0, 1'b1);
            7'd17:  u = ri(OP_MUL, 4'd3, 4'd2, 64'sd5, 1'b1);
            7'd18:  u = ri(OP_ADD, 4'd3, 4'd3, 64'sd128, 1'b1);
            7'd19:  u = ri(OP_ASR, REG_TEMP, 4'd3, 64'sd8, 1'b0);
            // Pressure
            7'd20:  u = fl(4'd0, F_ADC_P);
            7'd21:  u = ri(OP_SUB, 4'd1, REG_FINE, 64'sd128000, 1'b0);
            7'd22:  u = rr(OP_MUL, 4'd2, 4'd1, 4'd1, 1'b0);
            7'd23:  u = fl(4'd3, F_P6);
            7'd24:  u = rr(OP_MUL, 4'd3, 4'd2, 4'd3, 1'b0);
            7'd25:  u = fl(4'd4, F_P5);
            7'd26:  u = rr(OP_MUL, 4'd4, 4'd1, 4'd4, 1'b0);
            7'd27:  u = ri(OP_MUL, 4'd4, 4'd4, 64'sd131072, 1'b0);
            7'd28:  u = rr(OP_ADD, 4'd3, 4'd3, 4'd4, 1'b0);
            7'd29:  u = fl(4'd4, F_P4);
            7'd30:  u = ri(OP_MUL, 4'd4, 4'd4, 64'sd34359738368, 1'b0);
            7'd31:  u = rr(OP_ADD, 4'd3, 4'd3, 4'd4, 1'b0);
            7'd32:  u = fl(4'd4, F_P3);
            7'd33:  u = rr(OP_MUL, 4'd4, 4'd2, 4'd4, 1'b0);
            7'd34:  u = ri(OP_ASR, 4'd4, 4'd4, 64'sd8, 1'b0);
            7'd35:  u = fl(4'd5, F_P2);
            7'd36:  u = rr(OP_MUL, 4'd5, 4'd1, 4'd5, 1'b0);
            7'd37:  u = ri(OP_MUL, 4'd5, 4'd5, 64'sd4096, 1'b0);
            7'd38:  u = rr(OP_ADD, 4'd4, 4'd4, 4'd5, 1'b0);
            7'd39:  u = ri(OP_ADD, 4'd4, 4'd4, 64'sd140737488355328, 1'b0);
            7'd40:  u = fl(4'd5, F_P1);
            7'd41:  u = rr(OP_MUL, 4'd4, 4'd4, 4'd5, 1'b0);
            7'd42:  u = ri(OP_ASR, REG_V1, 4'd4, 64'sd33, 1'b0);
            7'd43:  u = ri(OP_SUB, 4'd4, 4'd0, 64'sd1048576, 1'b0);
            7'd44:  u = ri(OP_MUL, 4'd4, 4'd4, -64'sd2147483648, 1'b0);
            7'd45:  u = rr(OP_SUB, 4'd4, 4'd4, 4'd3, 1'b0);
            7'd46:  u = ri(OP_MUL, 4'd4, 4'd4, 64'sd3125, 1'b0);
            7'd47:  u = rr(OP_DIV, 4'd4, 4'd4, REG_V1, 1'b0);
            7'd48:  u = ri(OP_ASR, 4'd5, 4'd4, 64'sd13, 1'b0);
            7'd49:  u = fl(4'd6, F_P9);
            7'd50:  u = rr(OP_MUL, 4'd6, 4'd6, 4'd5, 1'b0);
            7'd51:  u = rr(OP_MUL, 4'd6, 4'd6, 4'd5, 1'b0);
            7'd52:  u = ri(OP_ASR, 4'd6, 4'd6, 64'sd25, 1'b0);
            7'd53:  u = fl(4'd7, F_P8);
            7'd54:  u = rr(OP_MUL, 4'd7, 4'd7, 4'd4, 1'b0);
            7'd55:  u = ri(OP_ASR, 4'd7, 4'd7, 64'sd19, 1'b0);
            7'd56:  u = rr(OP_ADD, 4'd4, 4'd4, 4'd6, 1'b0);
            7'd57:  u = rr(OP_ADD, 4'd4, 4'd4, 4'd7, 1'b0);
            7'd58:  u = ri(OP_ASR, 4'd4, 4'd4, 64'sd8, 1'b0);
            7'd59:  u = fl(4'd5, F_P7);
            7'd60:  u = ri(OP_MUL, 4'd5, 4'd5, 64'sd16, 1'b0);
            7'd61:  u = rr(OP_ADD, 4'd4, 4'd4, 4'd5, 1'b0);
            7'd62:  u = ri(OP_MIN, 4'd4, 4'd4, 64'sd2147483647, 1'b0);
            7'd63:  u = ri(OP_MAX, REG_PRES, 4'd4, -64'sd2147483648, 1'b0);
            // Humidity
            7'd64:  u = ri(OP_SUB, 4'd1, REG_FINE, 64'sd76800, 1'b1);
            7'd65:  u = fl(4'd0, F_RH);
            7'd66:  u = ri(OP_MUL, 4'd2, 4'd0, 64'sd16384, 1'b1);
            7'd67:  u = fl(4'd3, F_H4);
            7'd68:  u = ri(OP_MUL, 4'd3, 4'd3, 64'sd1048576, 1'b1);
            7'd69:  u = fl(4'd4, F_H5);
            7'd70:  u = rr(OP_MUL, 4'd4, 4'd4, 4'd1, 1'b1);
            7'd71:  u = rr(OP_SUB, 4'd2, 4'd2, 4'd3, 1'b1);
            7'd72:  u = rr(OP_SUB, 4'd2, 4'd2, 4'd4, 1'b1);
            7'd73:  u = ri(OP_ADD, 4'd2, 4'd2, 64'sd16384, 1'b1);
            7'd74:  u = ri(OP_ASR, 4'd2, 4'd2, 64'sd15, 1'b0);
            7'd75:  u = fl(4'd3, F_H6);
            7'd76:  u = rr(OP_MUL, 4'd3, 4'd1, 4'd3, 1'b1);
            7'd77:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd10, 1'b0);
            7'd78:  u = fl(4'd4, F_H3);
            7'd79:  u = rr(OP_MUL, 4'd4, 4'd1, 4'd4, 1'b1);
            7'd80:  u = ri(OP_ASR, 4'd4, 4'd4, 64'sd11, 1'b0);
            7'd81:  u = ri(OP_ADD, 4'd4, 4'd4, 64'sd32768, 1'b1);
            7'd82:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd4, 1'b1);
            7'd83:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd10, 1'b0);
            7'd84:  u = ri(OP_ADD, 4'd3, 4'd3, 64'sd2097152, 1'b1);
            7'd85:  u = fl(4'd4, F_H2);
            7'd86:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd4, 1'b1);
            7'd87:  u = ri(OP_ADD, 4'd3, 4'd3, 64'sd8192, 1'b1);
            7'd88:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd14, 1'b0);
            7'd89:  u = rr(OP_MUL, 4'd2, 4'd2, 4'd3, 1'b1);
            7'd90:  u = ri(OP_ASR, 4'd3, 4'd2, 64'sd15, 1'b0);
            7'd91:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd3, 1'b1);
            7'd92:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd7, 1'b0);
            7'd93:  u = fl(4'd4, F_H1);
            7'd94:  u = rr(OP_MUL, 4'd3, 4'd3, 4'd4, 1'b1);
            7'd95:  u = ri(OP_ASR, 4'd3, 4'd3, 64'sd4, 1'b0);
            7'd96:  u = rr(OP_SUB, 4'd2, 4'd2, 4'd3, 1'b1);
            7'd97:  u = ri(OP_MAX, 4'd2, 4'd2, 64'sd0, 1'b0);
            7'd98:  u = ri(OP_MIN, 4'd2, 4'd2, 64'sd419430400, 1'b0);
            7'd99:  u = ri(OP_ASR, REG_HUM, 4'd2, 64'sd12, 1'b0);
            default: u = rr(OP_END, 4'd0, 4'd0, 4'd0, 1'b0);
        endcase
        return u;
    endfunction

endpackage

### hdl/esc_meas_if.sv
// ----------------------------------------------------------------------------
// Measurement channel interface
// Valid/ready channel carrying one raw measurement set per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface esc_meas_if;
    logic                valid;
    logic                ready;
    esc_pkg::raw_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/esc_result_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one compensated result set per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface esc_result_if;
    logic                valid;
    logic                ready;
    esc_pkg::comp_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// Compensation controller
// Sequences the micro-operation program and handles the input handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  esc_pkg::dp_status_t    status,
    output esc_pkg::ctrl_cmd_t     cmd
);

    esc_pkg::ctrl_state_t          state_reg;
    esc_pkg::ctrl_state_t          state_next;
    logic [esc_pkg::PC_W-1:0]      pc_reg;
    logic [esc_pkg::PC_W-1:0]      pc_next;
    esc_pkg::uop_t                 uop;

    assign uop = esc_pkg::prog(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esc_pkg::ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        in_ready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.read   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.finish = 1'b0;
        cmd.pc     = pc_reg;
        case (state_reg)
            esc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    pc_next    = '0;
                    state_next = esc_pkg::ST_READ;
                end
            end
            esc_pkg::ST_READ:
            begin
                if (uop.op == esc_pkg::OP_END)
                begin
                    state_next = esc_pkg::ST_DONE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = esc_pkg::ST_EXEC;
                end
            end
            esc_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (uop.op == esc_pkg::OP_MUL || uop.op == esc_pkg::OP_DIV)
                begin
                    state_next = esc_pkg::ST_WAIT;
                end
                else
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = esc_pkg::ST_READ;
                end
            end
            esc_pkg::ST_WAIT:
            begin
                if (status.unit_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = esc_pkg::ST_READ;
                end
            end
            esc_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = esc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/esc_datapath.sv
// ----------------------------------------------------------------------------
// Compensation datapath
// Calibration registers, working register file, ALU, shared multiplier,
// iterative divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  esc_pkg::raw_beat_t                in_data,
    input  esc_pkg::ctrl_cmd_t                cmd,
    output esc_pkg::dp_status_t               status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output esc_pkg::comp_beat_t               out_data
);

    logic [47:0]          temp_cal_reg;
    logic [47:0]          pres_cala_reg;
    logic [47:0]          pres_calb_reg;
    logic [47:0]          pres_calc_reg;
    logic [39:0]          hum_cala_reg;
    logic [23:0]          hum_calb_reg;
    logic [31:0]          fine_reg;
    esc_pkg::raw_beat_t   raw_reg;

    logic [63:0]          rf_mem [15];
    logic [63:0]          opa_reg;
    logic [63:0]          opb_reg;

    logic                 v1_zero_reg;
    logic [26:0]          temp_res_reg;
    logic [31:0]          pres_res_reg;
    logic [16:0]          hum_res_reg;

    logic                 mul_busy_reg;
    logic [1:0]           mul_step_reg;
    logic [63:0]          ma_reg;
    logic [63:0]          mb_reg;
    logic [63:0]          prod_reg;
    logic [63:0]          acc_reg;
    logic [31:0]          mul_x;
    logic [31:0]          mul_y;
    logic                 mul_wb;

    logic                 div_busy_reg;
    logic                 div_wb_reg;
    logic [5:0]           div_cnt_reg;
    logic                 div_neg_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          quo_reg;
    logic [63:0]          den_reg;
    logic [64:0]          rem_sh;
    logic [64:0]          rem_diff;

    logic                 out_valid_reg;
    esc_pkg::comp_beat_t  out_data_reg;

    esc_pkg::uop_t        uop;
    logic [63:0]          b_val;
    logic [63:0]          fld_val;
    logic [5:0]           sh;
    logic [63:0]          bias;
    logic [63:0]          asr_sum;
    logic [63:0]          alu_res;
    logic [63:0]          wb_raw;
    logic [63:0]          wb_data;
    logic                 wb_en;
    logic                 t_en;
    logic                 p_en;
    logic                 h_en;
    logic                 unit_start;

    assign uop   = esc_pkg::prog(cmd.pc);
    assign b_val = uop.use_imm ? uop.imm : opb_reg;
    assign t_en  = (raw_reg.raw_temperature != esc_pkg::RAW24_DISABLED);
    assign p_en  = (raw_reg.raw_pressure != esc_pkg::RAW24_DISABLED);
    assign h_en  = (raw_reg.raw_humidity != esc_pkg::RAW16_DISABLED);

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg  <= '0;
            pres_cala_reg <= '0;
            pres_calb_reg <= '0;
            pres_calc_reg <= '0;
            hum_cala_reg  <= '0;
            hum_calb_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esc_pkg::CFG_TEMP_CAL:  temp_cal_reg  <= cfg_data;
                esc_pkg::CFG_PRES_CALA: pres_cala_reg <= cfg_data;
                esc_pkg::CFG_PRES_CALB: pres_calb_reg <= cfg_data;
                esc_pkg::CFG_PRES_CALC: pres_calc_reg <= cfg_data;
                esc_pkg::CFG_HUM_CALA:  hum_cala_reg  <= cfg_data[39:0];
                esc_pkg::CFG_HUM_CALB:  hum_calb_reg  <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    // Calibration and measurement fields, extended to 64 bits.
    always_comb
    begin
        case (esc_pkg::fld_t'(uop.imm[4:0]))
            esc_pkg::F_ADC_T: fld_val = {44'd0, raw_reg.raw_temperature[23:4]};
            esc_pkg::F_ADC_P: fld_val = {44'd0, raw_reg.raw_pressure[23:4]};
            esc_pkg::F_RH:    fld_val = {48'd0, raw_reg.raw_humidity};
            esc_pkg::F_T1:    fld_val = {48'd0, temp_cal_reg[15:0]};
            esc_pkg::F_T2:    fld_val = {{48{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
            esc_pkg::F_T3:    fld_val = {{48{temp_cal_reg[47]}}, temp_cal_reg[47:32]};
            esc_pkg::F_P1:    fld_val = {48'd0, pres_cala_reg[15:0]};
            esc_pkg::F_P2:    fld_val = {{48{pres_cala_reg[31]}}, pres_cala_reg[31:16]};
            esc_pkg::F_P3:    fld_val = {{48{pres_cala_reg[47]}}, pres_cala_reg[47:32]};
            esc_pkg::F_P4:    fld_val = {{48{pres_calb_reg[15]}}, pres_calb_reg[15:0]};
            esc_pkg::F_P5:    fld_val = {{48{pres_calb_reg[31]}}, pres_calb_reg[31:16]};
            esc_pkg::F_P6:    fld_val = {{48{pres_calb_reg[47]}}, pres_calb_reg[47:32]};
            esc_pkg::F_P7:    fld_val = {{48{pres_calc_reg[15]}}, pres_calc_reg[15:0]};
            esc_pkg::F_P8:    fld_val = {{48{pres_calc_reg[31]}}, pres_calc_reg[31:16]};
            esc_pkg::F_P9:    fld_val = {{48{pres_calc_reg[47]}}, pres_calc_reg[47:32]};
            esc_pkg::F_H1:    fld_val = {56'd0, hum_cala_reg[7:0]};
            esc_pkg::F_H2:    fld_val = {{48{hum_cala_reg[23]}}, hum_cala_reg[23:8]};
            esc_pkg::F_H3:    fld_val = {56'd0, hum_cala_reg[31:24]};
            esc_pkg::F_H6:    fld_val = {{56{hum_cala_reg[39]}}, hum_cala_reg[39:32]};
            esc_pkg::F_H4:    fld_val = {{52{hum_calb_reg[11]}}, hum_calb_reg[11:0]};
            esc_pkg::F_H5:    fld_val = {{52{hum_calb_reg[23]}}, hum_calb_reg[23:12]};
            default:          fld_val = '0;
        endcase
    end

    // Combinational ALU. The shift form divides by a power of two, rounding
    // toward zero as a signed integer division does.
    always_comb
    begin
        sh      = uop.imm[5:0];
        bias    = opa_reg[63] ? ((64'd1 << sh) - 64'd1) : 64'd0;
        asr_sum = opa_reg + bias;
        case (uop.op)
            esc_pkg::OP_FLD: alu_res = fld_val;
            esc_pkg::OP_ADD: alu_res = opa_reg + b_val;
            esc_pkg::OP_SUB: alu_res = opa_reg - b_val;
            esc_pkg::OP_ASR: alu_res = 64'($signed(asr_sum) >>> sh);
            esc_pkg::OP_MIN: alu_res = ($signed(opa_reg) < $signed(b_val)) ? opa_reg : b_val;
            esc_pkg::OP_MAX: alu_res = ($signed(opa_reg) > $signed(b_val)) ? opa_reg : b_val;
            default:         alu_res = '0;
        endcase
    end

    assign unit_start = cmd.exec && (uop.op == esc_pkg::OP_MUL || uop.op == esc_pkg::OP_DIV);
    assign mul_wb     = mul_busy_reg && (mul_step_reg == 2'd3);

    always_comb
    begin
        if (mul_wb)
        begin
            wb_raw = acc_reg + {prod_reg[31:0], 32'd0};
        end
        else if (div_wb_reg)
        begin
            wb_raw = div_neg_reg ? (64'd0 - quo_reg) : quo_reg;
        end
        else
        begin
            wb_raw = alu_res;
        end
        wb_data = uop.wrap ? {{32{wb_raw[31]}}, wb_raw[31:0]} : wb_raw;
        wb_en   = (cmd.exec && !unit_start) || mul_wb || div_wb_reg;
    end

    // Register file with registered operand reads; index fifteen is the
    // fine temperature, which lives in its own register.
    always_ff @(posedge clk)
    begin
        if (wb_en && uop.dst != esc_pkg::REG_FINE)
        begin
            rf_mem[uop.dst] <= wb_data;
        end
        if (cmd.read)
        begin
            if (uop.src_a == esc_pkg::REG_FINE)
            begin
                opa_reg <= {{32{fine_reg[31]}}, fine_reg};
            end
            else
            begin
                opa_reg <= rf_mem[uop.src_a];
            end
            if (uop.src_b == esc_pkg::REG_FINE)
            begin
                opb_reg <= {{32{fine_reg[31]}}, fine_reg};
            end
            else
            begin
                opb_reg <= rf_mem[uop.src_b];
            end
        end
        if (cmd.start)
        begin
            raw_reg <= in_data;
        end
        if (wb_en)
        begin
            case (uop.dst)
                esc_pkg::REG_V1:   v1_zero_reg  <= (wb_data == 64'd0);
                esc_pkg::REG_TEMP: temp_res_reg <= wb_data[26:0];
                esc_pkg::REG_PRES: pres_res_reg <= wb_data[31:0];
                esc_pkg::REG_HUM:  hum_res_reg  <= wb_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_reg <= '0;
        end
        else if (wb_en && uop.dst == esc_pkg::REG_FINE && t_en)
        begin
            fine_reg <= wb_data[31:0];
        end
    end

    // Shared 32x32 multiplier: four steps build the low 64 bits of a product.
    always_comb
    begin
        case (mul_step_reg)
            2'd0:    begin mul_x = ma_reg[31:0];  mul_y = mb_reg[31:0];  end
            2'd1:    begin mul_x = ma_reg[31:0];  mul_y = mb_reg[63:32]; end
            default: begin mul_x = ma_reg[63:32]; mul_y = mb_reg[31:0];  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_step_reg <= '0;
        end
        else if (cmd.exec && uop.op == esc_pkg::OP_MUL)
        begin
            mul_busy_reg <= 1'b1;
            mul_step_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            mul_step_reg <= mul_step_reg + 1'b1;
            if (mul_step_reg == 2'd3)
            begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && uop.op == esc_pkg::OP_MUL)
        begin
            ma_reg <= opa_reg;
            mb_reg <= b_val;
        end
        if (mul_busy_reg)
        begin
            prod_reg <= 64'(mul_x) * 64'(mul_y);
            case (mul_step_reg)
                2'd1:    acc_reg <= prod_reg;
                2'd2:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    // Restoring divider on magnitudes, one quotient bit a cycle.
    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign rem_diff = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_wb_reg   <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_wb_reg <= 1'b0;
            if (cmd.exec && uop.op == esc_pkg::OP_DIV)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == 6'd63)
                begin
                    div_busy_reg <= 1'b0;
                    div_wb_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && uop.op == esc_pkg::OP_DIV)
        begin
            div_neg_reg <= opa_reg[63] ^ b_val[63];
            rem_reg     <= '0;
            quo_reg     <= opa_reg[63] ? (64'd0 - opa_reg) : opa_reg;
            den_reg     <= b_val[63] ? (64'd0 - b_val) : b_val;
        end
        else if (div_busy_reg)
        begin
            if (!rem_diff[64])
            begin
                rem_reg <= rem_diff[63:0];
            end
            else
            begin
                rem_reg <= rem_sh[63:0];
            end
            quo_reg <= {quo_reg[62:0], ~rem_diff[64]};
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.temperature_valid <= t_en;
            out_data_reg.temperature_centi <= t_en ? temp_res_reg : 27'd0;
            out_data_reg.humidity_valid    <= h_en;
            out_data_reg.humidity_q22_10   <= h_en ? hum_res_reg : 17'd0;
            if (!p_en)
            begin
                out_data_reg.pressure_status <= esc_pkg::PST_DISABLED;
                out_data_reg.pressure_q24_8  <= '0;
            end
            else if (v1_zero_reg)
            begin
                out_data_reg.pressure_status <= esc_pkg::PST_ZERO_DIV;
                out_data_reg.pressure_q24_8  <= '0;
            end
            else
            begin
                out_data_reg.pressure_status <= esc_pkg::PST_OK;
                out_data_reg.pressure_q24_8  <= pres_res_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.unit_done = mul_wb || div_wb_reg;

endmodule

### hdl/environment_sensor_compensation.sv
// Environment sensor compensation: integer compensation of one raw
// temperature, pressure and humidity measurement set per beat.
// Channels: meas carries raw words in, result carries compensated values out;
// both are valid/ready, a beat moving when valid and ready are high together.
// Calibration is loaded through cfg_we/cfg_index/cfg_data; the user must
// load it only while the block is idle, as the block does not enforce this;
// indexes beyond the six calibration registers are ignored.
// The micro-program has a hundred steps; each of the 29 multiplies runs on
// the shared 32x32 multiplier and the one pressure division runs in the
// bit-serial divider.
// The next beat is taken as soon as the previous set has reached the
// output register.
// Reset clears the calibration registers, the fine temperature and all
// control state; the output channel comes up empty.
// If the receiver stalls, the result is held in the output register and the
// block computes the next set, then waits for the register to drain.
// ----------------------------------------------------------------------------
// Environment sensor compensation top level
// Joins the controller and datapath to the channel interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "environment_sensor_compensation_assert.svh"

module environment_sensor_compensation
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [esc_pkg::CFG_DATA_W-1:0]    cfg_data,
    esc_meas_if.sink                          meas,
    esc_result_if.source                      result
);

    // Command and status buses between the sequencer and the datapath.
    esc_pkg::ctrl_cmd_t   cmd;
    esc_pkg::dp_status_t  status;

    // The controller owns the input handshake and walks the program.
    esc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (meas.valid),
        .in_ready (meas.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds calibration, working registers, arithmetic units
    // and the output register that decouples the result channel.
    esc_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (meas.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

    // An accepted beat is followed at once by the first operand read.
    `ESC_ASSERT_NXT(a_start_reads, clk, rst_n, meas.valid && meas.ready, cmd.read)
    // A result is only loaded when the output register can take it.
    `ESC_ASSERT_IMP(a_finish_free, clk, rst_n, cmd.finish, status.out_free)
    // Arithmetic units only complete while the sequencer is waiting for them.
    `ESC_ASSERT_IMP(a_unit_quiet, clk, rst_n, status.unit_done, !cmd.exec && !cmd.finish)

endmodule

### sim/esc_compensation_checker.sv
// ----------------------------------------------------------------------------
// Compensation checker
// Watches the configuration port and both channels. It predicts each result
// from its own copy of the calibration and the fine temperature, and compares
// every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_compensation_checker
    import esc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    esc_meas_if                   meas,
    esc_result_if                 result,
    output int                    errors,
    output int                    pending
);

    logic [47:0]        cal_shadow [6];
    logic signed [31:0] fine_shadow;
    comp_beat_t         expected_results [$];

    function automatic comp_beat_t compensate(raw_beat_t m);
        comp_beat_t         o;
        logic signed [31:0] adc, t1, t2, t3, ta, tb;
        longint             p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint             px, sq, v1, v2, q, num, e, f;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, hx, ha, hb, hc, r, s, u, w;
        o = '0;
        o.pressure_status = PST_DISABLED;
        if (m.raw_temperature != RAW24_DISABLED)
        begin
            adc = {12'd0, m.raw_temperature[23:4]};
            t1  = {16'd0, cal_shadow[0][15:0]};
            t2  = $signed(cal_shadow[0][31:16]);
            t3  = $signed(cal_shadow[0][47:32]);
            ta  = adc / 8 - t1 * 2;
            tb  = adc / 16 - t1;
            ta  = (ta * t2) / 2048;
            tb  = ((tb * tb) / 4096 * t3) / 16384;
            fine_shadow = ta + tb;
            ta  = (fine_shadow * 5 + 128) / 256;
            o.temperature_centi = ta[26:0];
            o.temperature_valid = 1'b1;
        end
        if (m.raw_pressure != RAW24_DISABLED)
        begin
            p1 = cal_shadow[1][15:0];
            p2 = $signed(cal_shadow[1][31:16]);
            p3 = $signed(cal_shadow[1][47:32]);
            p4 = $signed(cal_shadow[2][15:0]);
            p5 = $signed(cal_shadow[2][31:16]);
            p6 = $signed(cal_shadow[2][47:32]);
            p7 = $signed(cal_shadow[3][15:0]);
            p8 = $signed(cal_shadow[3][31:16]);
            p9 = $signed(cal_shadow[3][47:32]);
            px = longint'(fine_shadow) - 64'sd128000;
            sq = px * px;
            v2 = sq * p6 + px * p5 * 64'sd131072 + p4 * 64'sd34359738368;
            v1 = (sq * p3) / 64'sd256 + px * p2 * 64'sd4096;
            v1 = ((64'sd140737488355328 + v1) * p1) / 64'sd8589934592;
            if (v1 == 0)
            begin
                o.pressure_status = PST_ZERO_DIV;
            end
            else
            begin
                q   = 64'sd1048576 - longint'(m.raw_pressure[23:4]);
                num = (q * 64'sd2147483648 - v2) * 64'sd3125;
                // A divisor of minus one is a plain wrapped negation.
                q   = (v1 == -64'sd1) ? -num : num / v1;
                e   = ((p9 * (q / 64'sd8192)) * (q / 64'sd8192)) / 64'sd33554432;
                f   = (p8 * q) / 64'sd524288;
                q   = (q + e + f) / 64'sd256 + p7 * 64'sd16;
                if (q > 64'sd2147483647)
                    q = 64'sd2147483647;
                if (q < -64'sd2147483648)
                    q = -64'sd2147483648;
                o.pressure_q24_8  = q[31:0];
                o.pressure_status = PST_OK;
            end
        end
        if (m.raw_humidity != RAW16_DISABLED)
        begin
            h1 = {24'd0, cal_shadow[4][7:0]};
            h2 = $signed(cal_shadow[4][23:8]);
            h3 = {24'd0, cal_shadow[4][31:24]};
            h6 = $signed(cal_shadow[4][39:32]);
            h4 = $signed(cal_shadow[5][11:0]);
            h5 = $signed(cal_shadow[5][23:12]);
            hx = fine_shadow - 76800;
            ha = $signed({16'd0, m.raw_humidity}) * 16384;
            hb = h4 * 1048576;
            hc = h5 * hx;
            r  = (ha - hb - hc + 16384) / 32768;
            s  = (hx * h6) / 1024;
            u  = (hx * h3) / 2048;
            w  = (s * (u + 32768)) / 1024 + 2097152;
            s  = (w * h2 + 8192) / 16384;
            u  = r * s;
            w  = ((u / 32768) * (u / 32768)) / 128;
            r  = u - (w * h1) / 16;
            if (r < 0)
                r = 0;
            if (r > 419430400)
                r = 419430400;
            r  = r / 4096;
            o.humidity_q22_10 = r[16:0];
            o.humidity_valid  = 1'b1;
        end
        return o;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        comp_beat_t exp_beat;
        comp_beat_t act;
        if (!rst_n)
        begin
            foreach (cal_shadow[i])
                cal_shadow[i] = '0;
            fine_shadow = '0;
            errors      = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_CAL:  cal_shadow[0] = cfg_data;
                    CFG_PRES_CALA: cal_shadow[1] = cfg_data;
                    CFG_PRES_CALB: cal_shadow[2] = cfg_data;
                    CFG_PRES_CALC: cal_shadow[3] = cfg_data;
                    CFG_HUM_CALA:  cal_shadow[4] = {8'd0, cfg_data[39:0]};
                    CFG_HUM_CALB:  cal_shadow[5] = {24'd0, cfg_data[23:0]};
                    default:       ;
                endcase
            end
            if (meas.valid && meas.ready)
                expected_results.push_back(compensate(meas.data));
            if (result.valid && result.ready)
            begin
                act = result.data;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %p", $time, act);
                    errors++;
                end
                else
                begin
                    exp_beat = expected_results.pop_front();
                    if (act.temperature_centi !== exp_beat.temperature_centi)
                    begin
                        $display("%0t: temperature_centi expected %0d actual %0d", $time,
                                 exp_beat.temperature_centi, act.temperature_centi);
                        errors++;
                    end
                    if (act.temperature_valid !== exp_beat.temperature_valid)
                    begin
                        $display("%0t: temperature_valid expected %0b actual %0b", $time,
                                 exp_beat.temperature_valid, act.temperature_valid);
                        errors++;
                    end
                    if (act.pressure_q24_8 !== exp_beat.pressure_q24_8)
                    begin
                        $display("%0t: pressure_q24_8 expected %0d actual %0d", $time,
                                 exp_beat.pressure_q24_8, act.pressure_q24_8);
                        errors++;
                    end
                    if (act.pressure_status !== exp_beat.pressure_status)
                    begin
                        $display("%0t: pressure_status expected %0d actual %0d", $time,
                                 exp_beat.pressure_status, act.pressure_status);
                        errors++;
                    end
                    if (act.humidity_q22_10 !== exp_beat.humidity_q22_10)
                    begin
                        $display("%0t: humidity_q22_10 expected %0d actual %0d", $time,
                                 exp_beat.humidity_q22_10, act.humidity_q22_10);
                        errors++;
                    end
                    if (act.humidity_valid !== exp_beat.humidity_valid)
                    begin
                        $display("%0t: humidity_valid expected %0b actual %0b", $time,
                                 exp_beat.humidity_valid, act.humidity_valid);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Environment sensor compensation testbench
// Loads a series of calibration sets, from all zeros and all ones to typical
// sensor values, sends directed and random measurement sets under several
// idling patterns, and leaves all checking to the compensation checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import esc_pkg::*;

    // Indexes past the calibration list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // This leaves ample margin for one result even when the receiver
    // stalls hard.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 140;

    // Typical factory calibration of this sensor family.
    localparam logic [47:0] TYP_TEMP  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] TYP_PRESA = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] TYP_PRESB = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] TYP_PRESC = {16'd6000, 16'hC6F8, 16'd15500};
    localparam logic [47:0] TYP_HUMA  = {8'd0, 8'd30, 8'd0, 16'd362, 8'd75};
    localparam logic [47:0] TYP_HUMB  = {24'd0, 12'd50, 12'd313};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    idle_pct;
    logic                  sender_idles;
    logic                  receiver_stalls;
    int                    quiet_cycles;

    esc_meas_if   meas_ch();
    esc_result_if result_ch();

    environment_sensor_compensation u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch.sink),
        .result    (result_ch.source)
    );

    esc_compensation_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch),
        .result    (result_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether it stalls.
    always @(negedge clk)
    begin
        result_ch.ready <= !(receiver_stalls && $urandom_range(0, 99) < idle_pct);
    end

    // Watchdog: a run with no beat moving for a long time has hung.
    always @(posedge clk)
    begin
        if ((meas_ch.valid && meas_ch.ready) || (result_ch.valid && result_ch.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Write one calibration register; called at a falling edge.
    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [47:0] random48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Typical values with the low byte of every sixteen-bit word disturbed.
    function automatic logic [47:0] jitter(logic [47:0] value);
        return value ^ (random48() & 48'h00FF_00FF_00FF);
    endfunction

    // Load a calibration set once the block has drained; kind 3 rewrites only three registers.
    task automatic load_calibration(int kind);
        // Withdraw the last set so that it is not taken a second time.
        meas_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
        case (kind)
            0:
            begin
                write_cal(CFG_TEMP_CAL, TYP_TEMP);
                write_cal(CFG_PRES_CALA, TYP_PRESA);
                write_cal(CFG_PRES_CALB, TYP_PRESB);
                write_cal(CFG_PRES_CALC, TYP_PRESC);
                write_cal(CFG_HUM_CALA, TYP_HUMA);
                write_cal(CFG_HUM_CALB, TYP_HUMB);
            end
            1:
            begin
                for (int i = 0; i < 6; i++)
                    write_cal(i[CFG_IDX_W-1:0], '1);
            end
            2:
            begin
                for (int i = 0; i < 6; i++)
                    write_cal(i[CFG_IDX_W-1:0], '0);
            end
            3:
            begin
                // A zero P1 makes the pressure divisor zero.
                write_cal(CFG_TEMP_CAL, jitter(TYP_TEMP));
                write_cal(CFG_PRES_CALA, jitter(TYP_PRESA) & 48'hFFFF_FFFF_0000);
                write_cal(CFG_HUM_CALA, jitter(TYP_HUMA));
            end
            4:
            begin
                for (int i = 0; i < 6; i++)
                    write_cal(i[CFG_IDX_W-1:0], random48());
            end
            default:
            begin
                write_cal(CFG_TEMP_CAL, jitter(TYP_TEMP));
                write_cal(CFG_PRES_CALA, jitter(TYP_PRESA));
                write_cal(CFG_PRES_CALB, jitter(TYP_PRESB));
                write_cal(CFG_PRES_CALC, jitter(TYP_PRESC));
                write_cal(CFG_HUM_CALA, jitter(TYP_HUMA) | (random48() & 48'hFF_0000_0000));
                write_cal(CFG_HUM_CALB, random48());
            end
        endcase
        // Spare indexes are ignored by the block and by the checker alike.
        write_cal(CFG_SPARE_6, random48());
        write_cal(CFG_SPARE_7, random48());
    endtask

    // Present one measurement set and hold it until the block takes the beat.
    // Entered at a falling edge; valid stays high into the next beat unless
    // the sender chooses to idle.
    task automatic send_set(raw_beat_t beat);
        while (sender_idles && $urandom_range(0, 99) < idle_pct)
        begin
            meas_ch.valid <= 1'b0;
            @(negedge clk);
        end
        meas_ch.valid <= 1'b1;
        meas_ch.data  <= beat;
        do
            @(posedge clk);
        while (!meas_ch.ready);
        @(negedge clk);
    endtask

    // Raw words near a real sensor's working range, with the disabled marker
    // and arbitrary words mixed in now and then.
    function automatic logic [23:0] random_raw24();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return RAW24_DISABLED;
        if (pick < 30)
            return 24'($urandom());
        return {20'($urandom_range(250000, 650000)), 4'($urandom())};
    endfunction

    function automatic logic [15:0] random_raw16();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return RAW16_DISABLED;
        if (pick < 35)
            return 16'($urandom());
        return 16'($urandom_range(15000, 45000));
    endfunction

    task automatic set_idling(int mode);
        sender_idles    = (mode == 1) || (mode == 3);
        receiver_stalls = (mode == 2) || (mode == 3);
        idle_pct        = (mode == 3) ? 29 : 68;
    endtask

    initial
    begin
        raw_beat_t directed [$];
        raw_beat_t beat;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        meas_ch.valid   = 1'b0;
        meas_ch.data    = '0;
        result_ch.ready = 1'b1;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        idle_pct        = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // One set straight after reset, with every coefficient still zero.
        send_set('{raw_temperature: 24'h7EF000, raw_pressure: 24'h5A3000,
                   raw_humidity: 16'h6E00});
        load_calibration(0);

        // Directed sets: field extremes, disabled channels singly and all together, and
        // a disabled temperature that must reuse the previous fine value.
        directed.push_back('{24'h000000, 24'h000000, 16'h0000});
        directed.push_back('{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF});
        directed.push_back('{24'h7FFFFF, 24'h7FFFFF, 16'h7FFF});
        directed.push_back('{24'h800001, 24'h800001, 16'h8001});
        directed.push_back('{24'h80000F, 24'h80000F, 16'h800F});
        directed.push_back('{24'h7EF00F, 24'h5A3000, 16'h6E00});
        directed.push_back('{RAW24_DISABLED, 24'h5A3000, 16'h6E00});
        directed.push_back('{24'h7EF000, RAW24_DISABLED, 16'h6E00});
        directed.push_back('{24'h7EF000, 24'h5A3000, RAW16_DISABLED});
        directed.push_back('{RAW24_DISABLED, RAW24_DISABLED, RAW16_DISABLED});
        directed.push_back('{24'h000000, 24'h5A3000, 16'hFFFF});
        directed.push_back('{RAW24_DISABLED, 24'hFFFFFF, 16'h0000});
        directed.push_back('{24'hFFFFFF, 24'h000000, 16'h6E00});
        directed.push_back('{RAW24_DISABLED, 24'h000000, 16'hFFFF});
        directed.push_back('{24'h555555, 24'hAAAAAA, 16'h5555});
        directed.push_back('{24'hAAAAAA, 24'h555555, 16'hAAAA});
        foreach (directed[i])
            send_set(directed[i]);

        // Saturation and the zero divisor need odd calibration sets.
        load_calibration(1);
        send_set('{24'h7EF000, 24'h5A3000, 16'h6E00});
        send_set('{24'h000000, 24'hFFFFFF, 16'hFFFF});
        load_calibration(3);
        send_set('{24'h7EF000, 24'h5A3000, 16'h6E00});

        // Random phases, each with its own calibration and idling pattern.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                2:       load_calibration(2);
                4:       load_calibration(3);
                7:       load_calibration(4);
                9:       load_calibration(1);
                default: load_calibration(5);
            endcase
            set_idling(phase % 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                beat.raw_temperature = random_raw24();
                beat.raw_pressure    = random_raw24();
                beat.raw_humidity    = random_raw16();
                send_set(beat);
            end
        end
        meas_ch.valid <= 1'b0;

        // Drain, then give the block a little longer to show any stray beat.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
